>>> rtl/core/wspc_pkg.sv
// Package: shared types and constants for the WAV stream parser.
`default_nettype none
package wspc_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;
   localparam int unsigned QDEPTH   = 4;
   localparam int unsigned QAW      = 2;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_FORMAT = 2'd1,
      KIND_ERROR  = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_SHORT   = 3'd0,
      ERR_RIFF    = 3'd1,
      ERR_FMT     = 3'd2,
      ERR_NOT_PCM = 3'd3,
      ERR_NO_DATA = 3'd4,
      ERR_DEPTH   = 3'd5
   } err_type;

   typedef enum logic [2:0] {
      PH_HDR      = 3'd0,
      PH_SKIP     = 3'd1,
      PH_CID      = 3'd2,
      PH_SKIPSIZE = 3'd3,
      PH_DATASIZE = 3'd4,
      PH_DATA     = 3'd5,
      PH_DONE     = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_DIV  = 2'd1,
      BK_EMIT = 2'd2
   } back_state_type;

   // classified byte handed from front to back
   typedef struct packed {
      logic       first;
      logic       last;
      logic [7:0] data;
   } word_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] sample_value;
      logic [15:0] channel_index;
      logic [31:0] frame_number;
      logic [31:0] rate_hz;
      logic [15:0] channel_count;
      logic [15:0] sample_bits;
      logic [31:0] frame_total;
      err_type     error_code;
      logic        last_of_run;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/core/wspc_if.sv
// Interfaces: request and response stream channels.
`default_nettype none
interface wspc_req_if import wspc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       first_byte;
   logic       final_byte;
   modport source (output valid, in_byte, first_byte, final_byte, input ready);
   modport sink (input valid, in_byte, first_byte, final_byte, output ready);
endinterface

interface wspc_rsp_if import wspc_pkg::*; ();
   logic        valid;
   logic        ready;
   rsp_type     payload;
   modport source (output valid, payload, input ready);
   modport sink (input valid, payload, output ready);
endinterface
`default_nettype wire

>>> rtl/core/wav_stream_parser_pcm_converter_top.sv
// Top level: WAV byte stream parser and PCM sample converter.
//  channel | dir | payload
//  req_    | in  | in_byte, first_byte, final_byte
//  rsp_    | out | kind, sample, format, error fields, last_of_run
// A byte with no result is consumed in the back end's idle state; each result is then
// held on the response register until taken. The data chunk header starts a
// restoring divider for the frame total. Synchronous reset clears the parser.
// The four-word queue lets the request side take up to four bytes while rsp_ stalls.
`default_nettype none
module wav_stream_parser_pcm_converter_top import wspc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   wspc_req_if.sink     req_ch,
   wspc_rsp_if.source   rsp_ch
);
   logic     q_full, q_push, q_pop, q_empty;
   word_type q_in_word, q_out_word;

   wspc_front u_front (
      .req(req_ch), .q_full(q_full), .q_push(q_push), .q_word(q_in_word)
   );

   wspc_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_word(q_in_word),
      .full(q_full), .pop(q_pop), .pop_word(q_out_word), .empty(q_empty)
   );

   wspc_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_word(q_out_word),
      .q_pop(q_pop), .rsp(rsp_ch)
   );
endmodule
`default_nettype wire

>>> rtl/core/wspc_queue.sv
// Module: short word queue between the front and back parts.
`default_nettype none
module wspc_queue import wspc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  word_type      push_word,
   output logic          full,
   input  wire logic     pop,
   output word_type      pop_word,
   output logic          empty
);
   word_type          mem_ff [QDEPTH];
   logic [QAW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [QAW:0]      cnt_ff, cnt_in;

   assign full     = (cnt_ff == (QAW+1)'(QDEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_word = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff + QAW'(push);
      rd_in  = rd_ff + QAW'(pop);
      cnt_in = cnt_ff + (QAW+1)'(push) - (QAW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_word;
   end
endmodule
`default_nettype wire

>>> rtl/core/wspc_front.sv
// Module: input front, takes request words into the queue.
`default_nettype none
module wspc_front import wspc_pkg::*; (
   wspc_req_if.sink     req,
   input  wire logic    q_full,
   output logic         q_push,
   output word_type     q_word
);
   assign req.ready    = !q_full;
   assign q_push       = req.valid && !q_full;
   assign q_word.first = req.first_byte;
   assign q_word.last  = req.final_byte;
   assign q_word.data  = req.in_byte;
endmodule
`default_nettype wire

>>> rtl/core/wspc_back.sv
// Module: parser back end with frame-count divider and response register.
`default_nettype none
module wspc_back import wspc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_empty,
   input  word_type     q_word,
   output logic         q_pop,
   wspc_rsp_if.source   rsp
);
   back_state_type st_ff, st_in;
   phase_type      ph_ff, ph_in;
   logic [31:0]    pos_ff, pos_in, sh_ff, sh_in, fmtl_ff, fmtl_in;
   logic [15:0]    chn_ff, chn_in, bits_ff, bits_in;
   logic [31:0]    rate_ff, rate_in, skip_ff, skip_in, fb_ff, fb_in;
   logic [31:0]    ftot_ff, ftot_in, fcnt_ff, fcnt_in;
   logic [15:0]    ccnt_ff, ccnt_in;
   logic [23:0]    gat_ff, gat_in;
   logic [1:0]     gc_ff, gc_in;
   // pending results (at most two)
   rsp_type        r0_ff, r0_in, r1_ff, r1_in;
   logic [1:0]     np_ff, np_in;
   logic           dlast_ff, dlast_in;
   // restoring divider
   logic [31:0]    dq_ff, dq_in, drem_ff, drem_in;
   logic [5:0]     dn_ff, dn_in;
   logic [32:0]    dtrial;
   logic [31:0]    w, pos, b32, fbw;
   logic [47:0]    prod;
   logic [1:0]     bps;
   logic [15:0]    v;
   logic           last;
   rsp_type        z;

   assign rsp.valid   = (st_ff == BK_EMIT);
   assign rsp.payload = r0_ff;
   assign dtrial      = {drem_ff, dq_ff[31]} - {1'b0, fb_ff};

   always_comb begin
      st_in = st_ff; ph_in = ph_ff; pos_in = pos_ff; sh_in = sh_ff; fmtl_in = fmtl_ff;
      chn_in = chn_ff; bits_in = bits_ff; rate_in = rate_ff; skip_in = skip_ff;
      fb_in = fb_ff; ftot_in = ftot_ff; fcnt_in = fcnt_ff; ccnt_in = ccnt_ff;
      gat_in = gat_ff; gc_in = gc_ff; r0_in = r0_ff; r1_in = r1_ff; np_in = np_ff;
      dlast_in = dlast_ff; dq_in = dq_ff; drem_in = drem_ff; dn_in = dn_ff;
      q_pop = 1'b0;
      z = '0;
      w = '0; pos = pos_ff; b32 = '0; v = '0; last = q_word.last;
      prod = '0; fbw = '0; bps = bits_ff[4:3];
      case (st_ff)
         BK_IDLE: if (!q_empty) begin
            q_pop = 1'b1;
            np_in = 2'd0;
            if (q_word.first) begin
               ph_in = PH_HDR; pos = '0; sh_in = '0; fmtl_in = '0; chn_in = '0;
               bits_in = '0; rate_in = '0; skip_in = '0; fb_in = '0; ftot_in = '0;
               fcnt_in = '0; ccnt_in = '0; gat_in = '0; gc_in = '0;
            end
            if (q_word.first || ph_ff != PH_DONE) begin
               pos_in = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
               b32 = {24'd0, q_word.data};
               w = {q_word.data, (q_word.first ? 24'd0 : sh_ff[31:8])};
               if (ph_in != PH_SKIP && ph_in != PH_DATA) sh_in = w;
               z = '0;
               case (ph_in)
                  PH_HDR: if (pos[1:0] == 2'd3) begin
                     case (pos[31:2])
                        30'd0: if (w != TAG_RIFF) begin
                           z.kind = KIND_ERROR; z.error_code = ERR_RIFF; ph_in = PH_DONE;
                        end
                        30'd2: if (w != TAG_WAVE) begin
                           z.kind = KIND_ERROR; z.error_code = ERR_RIFF; ph_in = PH_DONE;
                        end
                        30'd3: if (w != TAG_FMT) begin
                           z.kind = KIND_ERROR; z.error_code = ERR_FMT; ph_in = PH_DONE;
                        end
                        30'd4: begin
                           fmtl_in = w;
                           if (w < 32'd16) begin
                              z.kind = KIND_ERROR; z.error_code = ERR_FMT; ph_in = PH_DONE;
                           end
                        end
                        30'd5: begin
                           chn_in = w[31:16];
                           if (w[15:0] != 16'd1) begin
                              z.kind = KIND_ERROR; z.error_code = ERR_NOT_PCM;
                              ph_in = PH_DONE;
                           end
                        end
                        30'd6: rate_in = w;
                        30'd8: begin
                           bits_in = w[31:16];
                           skip_in = fmtl_ff - 32'd16;
                           ph_in = (skip_in != '0) ? PH_SKIP : PH_CID;
                           gc_in = '0;
                        end
                        default: ;
                     endcase
                     if (ph_in == PH_DONE) begin r0_in = z; np_in = 2'd1; end
                  end
                  PH_SKIP: begin
                     skip_in = skip_ff - 32'd1;
                     if (skip_in == '0) begin ph_in = PH_CID; gc_in = '0; end
                  end
                  PH_CID: if (gc_ff == 2'd3) begin
                     ph_in = (w == TAG_DATA) ? PH_DATASIZE : PH_SKIPSIZE; gc_in = '0;
                  end else gc_in = gc_ff + 2'd1;
                  PH_SKIPSIZE: if (gc_ff == 2'd3) begin
                     skip_in = w; ph_in = (w != '0) ? PH_SKIP : PH_CID; gc_in = '0;
                  end else gc_in = gc_ff + 2'd1;
                  PH_DATASIZE: if (gc_ff == 2'd3) begin
                     prod = {16'd0, chn_ff} * {16'd0, bits_ff};
                     fbw = prod[34:3];
                     fb_in = fbw;
                     if (fbw == '0) begin
                        z.kind = KIND_ERROR; z.error_code = ERR_DEPTH; ph_in = PH_DONE;
                        r0_in = z; np_in = 2'd1;
                     end else begin
                        // frame count division runs before the results go out
                        dq_in = w; drem_in = '0; dn_in = 6'd32; dlast_in = last;
                        fcnt_in = '0; ccnt_in = '0; gat_in = '0; gc_in = '0;
                        st_in = BK_DIV;
                     end
                     last = 1'b0;
                  end else gc_in = gc_ff + 2'd1;
                  PH_DATA: begin
                     gat_in = gat_ff | (24'(b32) << {gc_ff, 3'b000});
                     if ({1'b0, gc_ff} + 3'd1 < {1'b0, bps}) gc_in = gc_ff + 2'd1;
                     else begin
                        if (bps == 2'd1) v = {gat_in[7:0] ^ 8'h80, 8'h00};
                        else if (bps == 2'd2) v = gat_in[15:0];
                        else v = gat_in[23:8];
                        z.kind = KIND_SAMPLE; z.sample_value = v;
                        z.channel_index = ccnt_ff; z.frame_number = fcnt_ff;
                        r0_in = z; np_in = 2'd1;
                        gat_in = '0; gc_in = '0;
                        ccnt_in = ccnt_ff + 16'd1;
                        if (ccnt_in >= chn_ff) begin
                           ccnt_in = '0;
                           fcnt_in = fcnt_ff + 32'd1;
                           if (fcnt_in >= ftot_ff) begin
                              r1_in = '0; r1_in.kind = KIND_END;
                              r1_in.frame_number = fcnt_in;
                              np_in = 2'd2; ph_in = PH_DONE;
                           end
                        end
                     end
                  end
                  default: ph_in = PH_DONE;
               endcase
               if (last && ph_in != PH_DONE) begin
                  z = '0;
                  if (ph_in == PH_DATA) begin
                     z.kind = KIND_END; z.frame_number = fcnt_in;
                  end else begin
                     z.kind = KIND_ERROR;
                     z.error_code = (pos < 32'd43) ? ERR_SHORT : ERR_NO_DATA;
                  end
                  ph_in = PH_DONE;
                  if (np_in == 2'd0) r0_in = z; else r1_in = z;
                  np_in = np_in + 2'd1;
               end
               if (st_in == BK_IDLE && np_in != 2'd0) begin
                  if (np_in == 2'd1) r0_in.last_of_run = 1'b1;
                  else r1_in.last_of_run = 1'b1;
                  st_in = BK_EMIT;
               end
            end
         end
         BK_DIV: begin
            if (!dtrial[32]) begin
               drem_in = dtrial[31:0]; dq_in = {dq_ff[30:0], 1'b1};
            end else begin
               drem_in = {drem_ff[30:0], dq_ff[31]}; dq_in = {dq_ff[30:0], 1'b0};
            end
            dn_in = dn_ff - 6'd1;
            if (dn_ff == 6'd1) begin
               ftot_in = dq_in;
               z = '0; z.kind = KIND_FORMAT; z.rate_hz = rate_ff;
               z.channel_count = chn_ff; z.sample_bits = bits_ff; z.frame_total = dq_in;
               r0_in = z; r1_in = '0; np_in = 2'd2;
               if (dq_in == '0) begin
                  r1_in.kind = KIND_END; r1_in.frame_number = '0; ph_in = PH_DONE;
               end else if (bits_ff != 16'd8 && bits_ff != 16'd16 && bits_ff != 16'd24) begin
                  r1_in.kind = KIND_ERROR; r1_in.error_code = ERR_DEPTH; ph_in = PH_DONE;
               end else if (dlast_ff) begin
                  r1_in.kind = KIND_END; r1_in.frame_number = '0; ph_in = PH_DONE;
               end else begin
                  ph_in = PH_DATA; np_in = 2'd1;
               end
               if (np_in == 2'd1) r0_in.last_of_run = 1'b1;
               else r1_in.last_of_run = 1'b1;
               st_in = BK_EMIT;
            end
         end
         BK_EMIT: if (rsp.ready) begin
            if (np_ff == 2'd2) begin
               r0_in = r1_ff; np_in = 2'd1;
            end else begin
               np_in = 2'd0; st_in = BK_IDLE;
            end
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE; ph_ff <= PH_HDR; pos_ff <= '0; sh_ff <= '0; fmtl_ff <= '0;
         chn_ff <= '0; bits_ff <= '0; rate_ff <= '0; skip_ff <= '0; fb_ff <= '0;
         ftot_ff <= '0; fcnt_ff <= '0; ccnt_ff <= '0; gat_ff <= '0; gc_ff <= '0;
         np_ff <= '0;
      end else begin
         st_ff <= st_in; ph_ff <= ph_in; pos_ff <= pos_in; sh_ff <= sh_in;
         fmtl_ff <= fmtl_in; chn_ff <= chn_in; bits_ff <= bits_in; rate_ff <= rate_in;
         skip_ff <= skip_in; fb_ff <= fb_in; ftot_ff <= ftot_in; fcnt_ff <= fcnt_in;
         ccnt_ff <= ccnt_in; gat_ff <= gat_in; gc_ff <= gc_in; np_ff <= np_in;
      end
      r0_ff <= r0_in; r1_ff <= r1_in; dlast_ff <= dlast_in;
      dq_ff <= dq_in; drem_ff <= drem_in; dn_ff <= dn_in;
   end
endmodule
`default_nettype wire
